/* design/vvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvc_pkg
// Shared types and constants for the verb value cache.
// ----------------------------------------------------------------------------
package vvc_pkg;

    localparam int KEY_W   = 11;
    localparam int VALUE_W = 32;
    localparam int LANE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int VERB_W  = 12;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_vvc_cmd;

    typedef struct packed {
        logic scan_last;
    } t_vvc_sts;

endpackage

/* design/vvc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvc_ctrl
// Sequencer that accepts a word, steps the entry scan and commits the result.
// ----------------------------------------------------------------------------
module vvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  vvc_pkg::t_vvc_sts i_sts,
    output vvc_pkg::t_vvc_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_commit    = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load   = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.commit = w_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_sts.scan_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/vvc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvc_datapath
// Entry memory, valid bits, scan compare and result registers.
// ----------------------------------------------------------------------------
module vvc_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vvc_pkg::t_vvc_cmd             i_cmd,
    output vvc_pkg::t_vvc_sts             o_sts,
    input  logic                          i_kind,
    input  logic [vvc_pkg::LANE_W-1:0]    i_byte_lane,
    input  logic [vvc_pkg::VERB_W-1:0]    i_verb_code,
    input  logic [vvc_pkg::BYTE_W-1:0]    i_payload,
    output logic [vvc_pkg::VALUE_W-1:0]   o_read_value,
    output logic                          o_store_full
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW = vvc_pkg::KEY_W + vvc_pkg::VALUE_W;

    logic [EW-1:0]              r_mem [ENTRIES];
    logic                       r_valid [ENTRIES];

    logic                       r_kind;
    logic [vvc_pkg::LANE_W-1:0] r_lane;
    logic [vvc_pkg::KEY_W-1:0]  r_key;
    logic [vvc_pkg::BYTE_W-1:0] r_byte;

    logic [IW-1:0]              r_addr;
    logic                       r_cmp_en;
    logic                       r_cmp_vld;
    logic [IW-1:0]              r_cmp_idx;
    logic [EW-1:0]              r_rd_data;

    logic                       r_hit;
    logic [IW-1:0]              r_hit_idx;
    logic [vvc_pkg::VALUE_W-1:0] r_hit_val;
    logic                       r_free;
    logic [IW-1:0]              r_free_idx;

    logic [vvc_pkg::VALUE_W-1:0] r_read_value;
    logic                        r_store_full;

    logic [vvc_pkg::KEY_W-1:0]   w_verb_key;
    logic [vvc_pkg::VALUE_W-1:0] w_mask;
    logic [vvc_pkg::VALUE_W-1:0] w_data;
    logic [vvc_pkg::VALUE_W-1:0] w_merged;
    logic [4:0]                  w_shift;

    assign w_verb_key = i_verb_code[vvc_pkg::KEY_W-1:0];
    assign w_shift    = {r_lane, 3'b000};
    assign w_mask     = 32'h0000_00ff << w_shift;
    assign w_data     = {24'd0, r_byte} << w_shift;
    assign w_merged   = (r_hit_val & ~w_mask) | w_data;

    assign o_sts.scan_last = (r_addr == IW'(ENTRIES - 1));
    assign o_read_value    = r_read_value;
    assign o_store_full    = r_store_full;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_lane <= i_byte_lane;
            r_byte <= i_payload;
            if (i_kind == vvc_pkg::KIND_SET) begin
                r_key <= w_verb_key - {{(vvc_pkg::KEY_W - vvc_pkg::LANE_W){1'b0}}, i_byte_lane};
            end else begin
                r_key <= w_verb_key;
            end
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_addr];
            r_cmp_idx <= r_addr;
        end
        if (i_cmd.commit && (r_kind == vvc_pkg::KIND_SET)) begin
            if (r_hit) begin
                r_mem[r_hit_idx] <= {r_key, w_merged};
            end else if (r_free) begin
                r_mem[r_free_idx] <= {r_key, w_data};
            end
        end
        if (r_cmp_en && r_cmp_vld && !r_hit
                && (r_rd_data[EW-1:vvc_pkg::VALUE_W] == r_key)) begin
            r_hit_idx <= r_cmp_idx;
            r_hit_val <= r_rd_data[vvc_pkg::VALUE_W-1:0];
        end
        if (r_cmp_en && !r_cmp_vld && !r_free) begin
            r_free_idx <= r_cmp_idx;
        end
        if (i_cmd.commit) begin
            r_read_value <= ((r_kind == vvc_pkg::KIND_GET) && r_hit) ? r_hit_val : '0;
            r_store_full <= (r_kind == vvc_pkg::KIND_SET) && !r_hit && !r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_cmp_en  <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.load) begin
                r_addr   <= '0;
                r_cmp_en <= 1'b0;
                r_hit    <= 1'b0;
                r_free   <= 1'b0;
            end else begin
                if (r_cmp_en && r_cmp_vld
                        && (r_rd_data[EW-1:vvc_pkg::VALUE_W] == r_key)) begin
                    r_hit <= 1'b1;
                end
                if (r_cmp_en && !r_cmp_vld) begin
                    r_free <= 1'b1;
                end
                r_cmp_en <= i_cmd.scan;
                if (i_cmd.scan) begin
                    r_cmp_vld <= r_valid[r_addr];
                    if (!o_sts.scan_last) begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
            end
            if (i_cmd.commit && (r_kind == vvc_pkg::KIND_SET) && !r_hit && r_free) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

endmodule

/* design/verb_value_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// verb_value_cache_core
// Associative store of codec verb words with byte-lane set and word get.
// ----------------------------------------------------------------------------
// Each accepted word steps through the scan, drain and commit states: the scan
// reads the entry memory one entry at a time through its single read port, the
// drain state makes the last compare and the commit state registers the result.
// A new word is accepted only in the idle state that follows each commit, and a
// commit waits while an earlier result has not been taken.
// Reset clears all valid bits together; no clearing pass is needed.
module verb_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [vvc_pkg::LANE_W-1:0]  i_byte_lane,
    input  logic [vvc_pkg::VERB_W-1:0]  i_verb_code,
    input  logic [vvc_pkg::BYTE_W-1:0]  i_payload,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [vvc_pkg::VALUE_W-1:0] o_read_value,
    output logic                        o_store_full
);

    vvc_pkg::t_vvc_cmd w_cmd;
    vvc_pkg::t_vvc_sts w_sts;

    vvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    vvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_kind),
        .i_byte_lane  (i_byte_lane),
        .i_verb_code  (i_verb_code),
        .i_payload    (i_payload),
        .o_read_value (o_read_value),
        .o_store_full (o_store_full)
    );

endmodule
